>>> rtl/icfm_pkg.sv
`timescale 1ns / 1ps

package icfm_pkg;

	// Field widths fixed by the interface.
	localparam int CAPTURE_W  = 16;
	localparam int TCLK_W     = 27;
	localparam int PRESCALE_W = 4;
	localparam int FREQ_W     = 30;
	localparam int PERIOD_W   = 17;
	localparam int TERM_W     = TCLK_W + PRESCALE_W;
	localparam int DIV_CNT_W  = $clog2(TCLK_W);
	localparam int MUL_CNT_W  = $clog2(PRESCALE_W);

	// Register reset values and the frequency ceiling.
	localparam logic [TCLK_W-1:0]     TCLK_RESET     = 27'd4000000;
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 4'd8;
	localparam logic [FREQ_W-1:0]     FREQ_MAX       = '1;

	typedef enum logic {
		OP_CAPTURE = 1'b0,
		OP_RESET   = 1'b1
	} op_t;

	typedef enum logic {
		REG_TIMER_CLOCK   = 1'b0,
		REG_EDGE_PRESCALE = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                  opcode;
		logic [CAPTURE_W-1:0] capture_value;
	} in_item_t;

	typedef struct packed {
		logic [FREQ_W-1:0]   frequency;
		logic [PERIOD_W-1:0] period_ticks;
		logic                measurement_done;
		logic                divide_error;
	} out_item_t;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} seq_status_t;

endpackage

>>> rtl/input_capture_frequency_meter_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   in_item (opcode, capture_value)
// out      output     out_valid / out_ready out_item (frequency, period_ticks, flags)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// A reset command, a first capture or equal captures skip the arithmetic units.
// A completed period runs 27 divider steps (one quotient bit each), a hand-off, 4 steps of
// the prescale multiplier, then reaches the final state, commits and hands over the result.
// A new item is taken while the previous result still waits in the output register; a
// result that cannot be handed over holds the sequencer in its final state.
// Reset clears the measurement phase, the estimate and out_valid, and presets the config.
module input_capture_frequency_meter_top
	import icfm_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  cfg_reg_t          cfg_index,
	input  logic [TCLK_W-1:0] cfg_data
);

	state_t                   state_q;
	state_t                   state_d;
	logic [TCLK_W-1:0]        tclk_q;
	logic [PRESCALE_W-1:0]    presc_q;
	logic                     pending_q;
	logic [CAPTURE_W-1:0]     first_cap_q;
	logic [PERIOD_W-1:0]      last_period_q;
	logic [FREQ_W-1:0]        freq_q;
	op_t                      op_q;
	logic [CAPTURE_W-1:0]     cap_q;
	logic [COUNTER_WIDTH-1:0] period_q;
	logic                     out_valid_q;
	out_item_t                out_item_q;

	logic [COUNTER_WIDTH-1:0] period_d;
	logic                     in_xfer;
	logic                     go_div;
	logic                     div_start;
	logic                     mul_start;
	logic                     commit;
	logic [TCLK_W-1:0]        quotient;
	logic [TERM_W-1:0]        term;
	seq_status_t              div_stat;
	seq_status_t              mul_stat;

	logic [TERM_W:0]          sum;
	logic [FREQ_W-1:0]        freq_avg;
	logic                     pending_n;
	logic [CAPTURE_W-1:0]     first_cap_n;
	logic [PERIOD_W-1:0]      last_period_n;
	logic [FREQ_W-1:0]        freq_n;
	logic                     meas_done_n;
	logic                     div_err_n;

	// Period of the incoming capture against the stored one, modulo the counter range.
	assign in_xfer  = in_valid && in_ready;
	assign period_d = COUNTER_WIDTH'(in_item.capture_value) - COUNTER_WIDTH'(first_cap_q);
	assign go_div   = (in_item.opcode == OP_CAPTURE) && pending_q && (period_d != '0);

	icfm_div #(
		.DIVISOR_W(COUNTER_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tclk_q),
		.divisor  (period_d),
		.quotient (quotient),
		.status   (div_stat)
	);

	icfm_smul u_smul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplicand (quotient),
		.multiplier   (presc_q),
		.product      (term),
		.status       (mul_stat)
	);

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = go_div ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid && go_div;
			end
			ST_DIV: begin
				mul_start = div_stat.done;
			end
			ST_MUL: begin
			end
			ST_DONE: begin
				commit = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	// Running average with saturation.
	assign sum      = {1'b0, TERM_W'(freq_q)} + {1'b0, term};
	assign freq_avg = sum[TERM_W] ? FREQ_MAX : sum[TERM_W-1:1];

	// Measurement state after the item being finished.
	always_comb begin
		pending_n     = pending_q;
		first_cap_n   = first_cap_q;
		last_period_n = last_period_q;
		freq_n        = freq_q;
		meas_done_n   = 1'b0;
		div_err_n     = 1'b0;
		if (op_q == OP_RESET) begin
			pending_n = 1'b0;
			freq_n    = '0;
		end else if (!pending_q) begin
			first_cap_n = cap_q;
			pending_n   = 1'b1;
		end else begin
			pending_n     = 1'b0;
			last_period_n = PERIOD_W'(period_q);
			meas_done_n   = 1'b1;
			if (period_q == '0) begin
				div_err_n = 1'b1;
			end else begin
				freq_n = freq_avg;
			end
		end
	end

	// Control and measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tclk_q        <= TCLK_RESET;
			presc_q       <= PRESCALE_RESET;
			pending_q     <= 1'b0;
			first_cap_q   <= '0;
			last_period_q <= '0;
			freq_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_TIMER_CLOCK:   tclk_q  <= cfg_data;
					REG_EDGE_PRESCALE: presc_q <= cfg_data[PRESCALE_W-1:0];
					default: begin
					end
				endcase
			end
			if (commit) begin
				pending_q     <= pending_n;
				first_cap_q   <= first_cap_n;
				last_period_q <= last_period_n;
				freq_q        <= freq_n;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= in_item.opcode;
			cap_q    <= in_item.capture_value;
			period_q <= period_d;
		end
		if (commit) begin
			out_item_q.frequency        <= freq_n;
			out_item_q.period_ticks     <= last_period_n;
			out_item_q.measurement_done <= meas_done_n;
			out_item_q.divide_error     <= div_err_n;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// The divider only runs while the sequencer waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> (state_q == ST_DIV))
		else $error("divider active outside the divide state");

	// The multiplier only runs while the sequencer waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_stat.busy || mul_stat.done) |-> (state_q == ST_MUL))
		else $error("multiplier active outside the multiply state");

	// A new result appears only after the sequencer finished an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result presented without a finished item");

	// A divide error is always part of a completed measurement.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.divide_error) |-> out_item.measurement_done)
		else $error("divide error without a completed measurement");

endmodule

>>> rtl/icfm_div.sv
`timescale 1ns / 1ps

module icfm_div
	import icfm_pkg::*;
#(
	parameter int DIVISOR_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TCLK_W-1:0]    dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic [TCLK_W-1:0]    quotient,
	output seq_status_t          status
);

	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [TCLK_W-1:0]    dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVISOR_W+1:0] trial;
	logic                 qbit;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign trial = {1'b0, rem_q, dvd_q[TCLK_W-1]} - {2'b00, dsr_q};
	assign qbit  = ~trial[DIVISOR_W+1];

	// Datapath: the dividend shifts out at the top while quotient bits fill the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[DIVISOR_W-1:0] : {rem_q[DIVISOR_W-2:0], dvd_q[TCLK_W-1]};
			dvd_q <= {dvd_q[TCLK_W-2:0], qbit};
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(TCLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/icfm_smul.sv
`timescale 1ns / 1ps

module icfm_smul
	import icfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TCLK_W-1:0]     multiplicand,
	input  logic [PRESCALE_W-1:0] multiplier,
	output logic [TERM_W-1:0]     product,
	output seq_status_t           status
);

	logic [TERM_W-1:0]     mcand_q;
	logic [PRESCALE_W-1:0] mplier_q;
	logic [TERM_W-1:0]     acc_q;
	logic [MUL_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	// Shift-and-add, one multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= TERM_W'(multiplicand);
			mplier_q <= multiplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[TERM_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[PRESCALE_W-1:1]};
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q == MUL_CNT_W'(PRESCALE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign product     = acc_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
